FILE: design/pesf_pkg.sv
// Shared types and constants for the PES packet framer.
// No dependencies; every design module imports this package.
package pesf_pkg;

  localparam int MAX_PACKET_LIMIT_DEF = 262144;
  localparam int CFG_W                = 19;
  localparam int MIN_PACKET           = 7;
  localparam int APB_ADDR_W           = 3;
  localparam int APB_DATA_W           = 32;

  localparam logic [CFG_W-1:0] MAX_PKT_RESET = 19'd262144;

  // Register index taken from the word address.
  localparam logic REG_MAX_PACKET_BYTES = 1'b0;

  // Input action codes.
  localparam logic ACT_DATA  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // Stream ids at or above this carry a usable length field.
  localparam logic [7:0] SID_BOUNDED_MIN = 8'hBC;

  typedef enum logic [3:0] {
    MODE_SEARCH  = 4'b0001,
    MODE_HEADER  = 4'b0010,
    MODE_BOUNDED = 4'b0100,
    MODE_SCAN    = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_kind;
    logic       first_of_packet;
    logic       last_of_packet;
    logic       status;
    logic       run_last;
  } res_t;

  typedef struct packed {
    logic push;
    logic take;
  } core_stat_t;

endpackage

FILE: design/pesf_if.sv
// Channel interfaces for the PES packet framer: byte input and result output.
// Plain valid/ready handshakes; no package dependency.
interface pesf_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface pesf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_kind;
  logic       first_of_packet;
  logic       last_of_packet;
  logic       status;
  logic       run_last;

  modport source (output valid, output out_byte, output byte_kind, output first_of_packet,
                  output last_of_packet, output status, output run_last, input ready);
  modport sink   (input valid, input out_byte, input byte_kind, input first_of_packet,
                  input last_of_packet, input status, input run_last, output ready);
endinterface

FILE: design/pes_packet_framer_top.sv
// Top level of the PES packet framer: register port, framing core, result buffer.
// Depends on pesf_pkg, pesf_if, pesf_cfg, pesf_core and pesf_out_buf.
//
// Usage: bytes enter on in_ch (action 0 = data byte, action 1 = end of input).
// Each byte is held in a three-byte look-behind window, so the result for a
// byte appears three data bytes after it arrived. A data byte that arrives
// while the window is full causes one result on out_ch; the first three bytes
// after reset or a flush cause none. An end-of-input request drains the window
// as up to three results, one per cycle while the output buffer has space, and
// ends any open packet. A request is registered in the input register when
// accepted, and its result is written from there into the output buffer, which
// drives out_ch. One data byte per cycle is taken while the output buffer has
// space, set by the single pass through the framing logic; a flush holds the
// input until it has drained the window.
// When the receiver stalls, a two-entry output buffer absorbs results; input
// ready drops once it is full, with no data lost. Reset (rst, synchronous)
// empties the window and the buffer, returns the framer to searching for a
// start code and sets max_packet_bytes to 262144.
module pes_packet_framer_top
  import pesf_pkg::*;
#(
  parameter int MAX_PACKET_LIMIT = MAX_PACKET_LIMIT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  pesf_in_if.sink               in_ch,
  pesf_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int OFF_W = $clog2(MAX_PACKET_LIMIT);

  logic [OFF_W-1:0] lim_m1;
  logic             space;
  core_stat_t       stat;
  res_t             res;

  pesf_cfg #(
    .MAX_PACKET_LIMIT(MAX_PACKET_LIMIT)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .lim_m1  (lim_m1)
  );

  pesf_core #(
    .MAX_PACKET_LIMIT(MAX_PACKET_LIMIT)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .lim_m1 (lim_m1),
    .space  (space),
    .stat   (stat),
    .res    (res)
  );

  pesf_out_buf u_out_buf (
    .clk    (clk),
    .rst    (rst),
    .stat   (stat),
    .res    (res),
    .space  (space),
    .out_ch (out_ch)
  );

`ifndef SYNTH
  // The core must never write a full buffer.
  assert property (@(posedge clk) disable iff (rst) stat.push |-> space)
    else $error("result written into a full output buffer");

  // The last result of a request always retires that request.
  assert property (@(posedge clk) disable iff (rst) (stat.push && res.run_last) |-> stat.take)
    else $error("request not retired with its last result");

  // Skipped bytes carry no packet markers.
  assert property (@(posedge clk) disable iff (rst)
    (stat.push && !res.byte_kind) |-> (!res.first_of_packet && !res.last_of_packet && !res.status))
    else $error("packet marker on a skipped byte");
`endif

endmodule

FILE: design/pesf_cfg.sv
// APB register for max_packet_bytes and the clamped packet limit derived from it.
// Depends on pesf_pkg.
module pesf_cfg
  import pesf_pkg::*;
#(
  parameter int MAX_PACKET_LIMIT = MAX_PACKET_LIMIT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [APB_ADDR_W-1:0]                 paddr,
  input  logic [APB_DATA_W-1:0]                 pwdata,
  output logic [APB_DATA_W-1:0]                 prdata,
  output logic                                  pready,
  output logic [$clog2(MAX_PACKET_LIMIT)-1:0]   lim_m1
);

  localparam int OFF_W = $clog2(MAX_PACKET_LIMIT);
  localparam int LIM_W = $clog2(MAX_PACKET_LIMIT + 1);
  localparam int CMP_W = (LIM_W > CFG_W) ? LIM_W : CFG_W;

  logic [CFG_W-1:0] max_packet_bytes;
  logic [CMP_W-1:0] cfg_ext;
  logic [CMP_W-1:0] lim;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_MAX_PACKET_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_bytes <= MAX_PKT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      max_packet_bytes <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = APB_DATA_W'(max_packet_bytes);
    end
  end

  // Out-of-range settings are pulled into the legal range.
  always_comb begin
    cfg_ext = CMP_W'(max_packet_bytes);
    if (cfg_ext < CMP_W'(MIN_PACKET)) begin
      lim = CMP_W'(MIN_PACKET);
    end else if (cfg_ext > CMP_W'(MAX_PACKET_LIMIT)) begin
      lim = CMP_W'(MAX_PACKET_LIMIT);
    end else begin
      lim = cfg_ext;
    end
  end

  assign lim_m1 = OFF_W'(lim - CMP_W'(1));

endmodule

FILE: design/pesf_core.sv
// Input register, three-byte look-behind window and per-byte framing logic.
// Depends on pesf_pkg and pesf_in_if; produces one result request per cycle at most.
module pesf_core
  import pesf_pkg::*;
#(
  parameter int MAX_PACKET_LIMIT = MAX_PACKET_LIMIT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  pesf_in_if.sink                             in_ch,
  input  logic [$clog2(MAX_PACKET_LIMIT)-1:0] lim_m1,
  input  logic                                space,
  output core_stat_t                          stat,
  output res_t                                res
);

  localparam int OFF_W = $clog2(MAX_PACKET_LIMIT);

  // Input register.
  logic       hold_valid;
  logic       hold_act;
  logic [7:0] hold_byte;

  // Framing state.
  logic [7:0]       w0, w1, w2;
  logic [7:0]       w0_next, w1_next, w2_next;
  logic [1:0]       fill, fill_next;
  logic [1:0]       idx, idx_next;
  mode_t            mode, mode_next;
  logic [OFF_W-1:0] off, off_next;
  logic [15:0]      dl, dl_next;

  // Per-byte classification.
  logic [7:0]       e_b;
  logic             e_start;
  logic             e_prefix;
  logic             e_final;
  logic             e_active;
  logic             e_first;
  logic             e_last;
  logic             e_over;
  mode_t            e_mode;
  mode_t            e_mode_out;
  logic [OFF_W-1:0] e_p;
  logic [OFF_W-1:0] e_off_out;
  logic [15:0]      e_dl;

  assign in_ch.ready = !hold_valid || stat.take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ch.ready) begin
      hold_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      hold_act  <= in_ch.action;
      hold_byte <= in_ch.data_byte;
    end
  end

  // Select the leaving byte and what lies ahead of it.
  always_comb begin
    e_start  = 1'b0;
    e_prefix = 1'b0;
    e_final  = 1'b0;
    if (hold_act == ACT_DATA) begin
      e_b      = w0;
      e_start  = (w0 == 8'h00) && (w1 == 8'h00) && (w2 == 8'h01);
      e_prefix = (w1 == 8'h00) && (w2 == 8'h00) && (hold_byte == 8'h01);
    end else begin
      case (idx)
        2'd0:    e_b = w0;
        2'd1:    e_b = w1;
        default: e_b = w2;
      endcase
      // On a flush too few bytes follow to hold a start code.
      e_final = (idx == (fill - 2'd1));
    end
  end

  always_comb begin
    e_mode   = mode;
    e_p      = off;
    e_first  = 1'b0;
    e_active = 1'b1;
    e_last   = 1'b0;
    e_over   = 1'b0;
    e_dl     = dl;
    if (mode == MODE_SEARCH) begin
      if (e_start) begin
        e_mode  = MODE_HEADER;
        e_p     = '0;
        e_first = 1'b1;
      end else begin
        e_active = 1'b0;
      end
    end
    if (e_mode == MODE_HEADER) begin
      if (e_p == OFF_W'(3)) begin
        if (e_b < SID_BOUNDED_MIN) begin
          e_mode = MODE_SCAN;
        end
      end else if (e_p == OFF_W'(4)) begin
        e_dl = {e_b, 8'h00};
      end else if (e_p >= OFF_W'(5)) begin
        e_dl   = {dl[15:8], e_b};
        e_mode = (e_dl != 16'h0000) ? MODE_BOUNDED : MODE_SCAN;
      end
    end
    if (e_mode == MODE_SCAN) begin
      // A start code that would end past the limit does not count.
      if (e_prefix && ({1'b0, e_p} + (OFF_W+1)'(3) <= {1'b0, lim_m1})) begin
        e_last = 1'b1;
      end else if (e_p >= lim_m1) begin
        e_last = 1'b1;
        e_over = 1'b1;
      end
    end else if (e_mode == MODE_BOUNDED) begin
      if ({1'b0, e_p} >= (OFF_W+1)'(e_dl) + (OFF_W+1)'(5)) begin
        e_last = 1'b1;
      end
    end
    if (e_final) begin
      e_last = 1'b1;
    end
    if (!e_active) begin
      e_last     = 1'b0;
      e_over     = 1'b0;
      e_dl       = dl;
      e_mode_out = mode;
      e_off_out  = off;
    end else if (e_last) begin
      e_mode_out = MODE_SEARCH;
      e_off_out  = '0;
    end else begin
      e_mode_out = e_mode;
      e_off_out  = e_p + OFF_W'(1);
    end
  end

  always_comb begin
    res.out_byte        = e_b;
    res.byte_kind       = e_active;
    res.first_of_packet = e_first;
    res.last_of_packet  = e_last;
    res.status          = e_over;
    res.run_last        = (hold_act == ACT_DATA) ? 1'b1 : e_final;
  end

  always_comb begin
    w0_next   = w0;
    w1_next   = w1;
    w2_next   = w2;
    fill_next = fill;
    idx_next  = idx;
    mode_next = mode;
    off_next  = off;
    dl_next   = dl;
    stat.push = 1'b0;
    stat.take = 1'b0;
    if (hold_valid) begin
      if (hold_act == ACT_DATA) begin
        if (fill != 2'd3) begin
          // Window still filling: no result yet.
          stat.take = 1'b1;
          fill_next = fill + 2'd1;
          case (fill)
            2'd0:    w0_next = hold_byte;
            2'd1:    w1_next = hold_byte;
            default: w2_next = hold_byte;
          endcase
        end else if (space) begin
          stat.push = 1'b1;
          stat.take = 1'b1;
          mode_next = e_mode_out;
          off_next  = e_off_out;
          dl_next   = e_dl;
          w0_next   = w1;
          w1_next   = w2;
          w2_next   = hold_byte;
        end
      end else begin
        if (fill == 2'd0) begin
          stat.take = 1'b1;
          mode_next = MODE_SEARCH;
          off_next  = '0;
        end else if (space) begin
          stat.push = 1'b1;
          dl_next   = e_dl;
          if (e_final) begin
            stat.take = 1'b1;
            fill_next = 2'd0;
            idx_next  = 2'd0;
            mode_next = MODE_SEARCH;
            off_next  = '0;
          end else begin
            idx_next  = idx + 2'd1;
            mode_next = e_mode_out;
            off_next  = e_off_out;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
      idx  <= 2'd0;
      mode <= MODE_SEARCH;
      off  <= '0;
      dl   <= 16'h0000;
    end else begin
      fill <= fill_next;
      idx  <= idx_next;
      mode <= mode_next;
      off  <= off_next;
      dl   <= dl_next;
    end
  end

  always_ff @(posedge clk) begin
    w0 <= w0_next;
    w1 <= w1_next;
    w2 <= w2_next;
  end

endmodule

FILE: design/pesf_out_buf.sv
// Two-entry result buffer between the framing logic and the output channel.
// Depends on pesf_pkg and pesf_out_if; space is registered so input ready never
// waits on the output receiver.
module pesf_out_buf
  import pesf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  core_stat_t stat,
  input  res_t       res,
  output logic       space,
  pesf_out_if.source out_ch
);

  res_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;
  res_t       head;

  assign space = (count != 2'd2);
  assign pop   = (count != 2'd0) && out_ch.ready;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (stat.push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({stat.push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (stat.push) begin
      mem[wr_ptr] <= res;
    end
  end

  assign out_ch.valid           = (count != 2'd0);
  assign out_ch.out_byte        = head.out_byte;
  assign out_ch.byte_kind       = head.byte_kind;
  assign out_ch.first_of_packet = head.first_of_packet;
  assign out_ch.last_of_packet  = head.last_of_packet;
  assign out_ch.status          = head.status;
  assign out_ch.run_last        = head.run_last;

endmodule
